@@ sv/heap_sort_engine_unit_macros.svh @@
// Assertion helpers used by hse_ctrl.
`ifndef HEAP_SORT_ENGINE_UNIT_MACROS_SVH
`define HEAP_SORT_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hse: check failed");
`define HSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hse: check failed");
`else
`define HSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/hse_pkg.sv @@
package hse_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CAPACITY_DEF = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BLD_RD,
        ST_BLD_CAP,
        ST_SFT_RDL,
        ST_SFT_RDR,
        ST_SFT_CMP,
        ST_SD_RD0,
        ST_SD_RDJ,
        ST_SD_SW,
        ST_EM_RD,
        ST_EM_WR
    } hse_state_t;

    // one result beat handed from the sequencer to the output register
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } emit_t;

    function automatic logic value_less(input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

@@ sv/hse_ram.sv @@
module hse_ram import hse_pkg::*; #(
    parameter int unsigned DEPTH = CAPACITY_DEF,
    parameter int unsigned AW    = $clog2(CAPACITY_DEF)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hse_ctrl.sv @@
`include "heap_sort_engine_unit_macros.svh"

module hse_ctrl import hse_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    parameter int unsigned AW       = $clog2(CAPACITY_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_value,
    input  logic              in_last,
    input  logic              slot_free,
    output emit_t             emit,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;

    hse_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [AW-1:0]     bound_reg, bound_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              build_reg, build_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [DATA_W-1:0] lval_reg, lval_next;
    logic [DATA_W-1:0] root_reg, root_next;

    logic [IW-1:0]     lidx, ridx, bound_x;
    logic [CW-1:0]     n_fin;
    logic              take_r;
    logic [DATA_W-1:0] cval;
    logic [IW-1:0]     cidx;
    logic              sift_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg  <= node_next;
        bound_reg <= bound_next;
        idx_reg   <= idx_next;
        build_reg <= build_next;
        cur_reg   <= cur_next;
        lval_reg  <= lval_next;
        root_reg  <= root_next;
    end

    assign lidx    = {1'b0, node_reg, 1'b1};
    assign ridx    = {1'b0, node_reg, 1'b0} + IW'(2);
    assign bound_x = {2'b00, bound_reg};
    // right child only counts when it lies inside the heap
    assign take_r  = (ridx <= bound_x) && value_less(lval_reg, mem_rdata);
    assign cval    = take_r ? mem_rdata : lval_reg;
    assign cidx    = take_r ? ridx : lidx;
    assign n_fin   = (count_reg < CW'(CAPACITY)) ? count_reg + CW'(1) : count_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        node_next  = node_reg;
        bound_next = bound_reg;
        idx_next   = idx_reg;
        build_next = build_reg;
        cur_next   = cur_reg;
        lval_next  = lval_reg;
        root_next  = root_reg;
        in_ready   = 1'b0;
        emit       = '0;
        mem_we     = 1'b0;
        mem_waddr  = node_reg;
        mem_wdata  = cur_reg;
        mem_raddr  = '0;
        sift_done  = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (count_reg < CW'(CAPACITY)) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = in_value;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (in_last) begin
                        bound_next = AW'(n_fin - CW'(1));
                        if (n_fin < CW'(2)) begin
                            idx_next   = '0;
                            state_next = ST_EM_RD;
                        end else begin
                            idx_next   = AW'(((n_fin - CW'(1)) >> 1) + CW'(1));
                            state_next = ST_BLD_RD;
                        end
                    end
                end
            end
            ST_BLD_RD: begin
                mem_raddr  = idx_reg - AW'(1);
                node_next  = idx_reg - AW'(1);
                state_next = ST_BLD_CAP;
            end
            ST_BLD_CAP: begin
                cur_next   = mem_rdata;
                build_next = 1'b1;
                state_next = ST_SFT_RDL;
            end
            ST_SFT_RDL: begin
                if (lidx > bound_x) begin
                    mem_we    = 1'b1;
                    sift_done = 1'b1;
                end else begin
                    mem_raddr  = lidx[AW-1:0];
                    state_next = ST_SFT_RDR;
                end
            end
            ST_SFT_RDR: begin
                mem_raddr  = ridx[AW-1:0];
                lval_next  = mem_rdata;
                state_next = ST_SFT_CMP;
            end
            ST_SFT_CMP: begin
                mem_we = 1'b1;
                if (value_less(cur_reg, cval)) begin
                    // larger child moves up, the hole moves down
                    mem_wdata  = cval;
                    node_next  = cidx[AW-1:0];
                    state_next = ST_SFT_RDL;
                end else begin
                    sift_done = 1'b1;
                end
            end
            ST_SD_RD0: begin
                mem_raddr  = '0;
                state_next = ST_SD_RDJ;
            end
            ST_SD_RDJ: begin
                mem_raddr  = idx_reg;
                root_next  = mem_rdata;
                state_next = ST_SD_SW;
            end
            ST_SD_SW: begin
                cur_next   = mem_rdata;
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = root_reg;
                node_next  = '0;
                bound_next = idx_reg - AW'(1);
                build_next = 1'b0;
                state_next = ST_SFT_RDL;
            end
            ST_EM_RD: begin
                mem_raddr = idx_reg;
                if (slot_free) begin
                    state_next = ST_EM_WR;
                end
            end
            ST_EM_WR: begin
                emit.valid = 1'b1;
                emit.last  = (CW'(idx_reg) + CW'(1)) == count_reg;
                emit.ovf   = ovf_reg;
                if (emit.last) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_EM_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (sift_done) begin
            if (build_reg) begin
                if (idx_reg == AW'(1)) begin
                    idx_next   = bound_reg;
                    state_next = ST_SD_RD0;
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_BLD_RD;
                end
            end else begin
                if (idx_reg == AW'(1)) begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_SD_RD0;
                end
            end
        end
    end

    `HSE_ASSERT_IMP(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `HSE_ASSERT_IMP(a_emit_slot, aclk, aresetn, emit.valid, slot_free)
    `HSE_ASSERT_IMP(a_cmp_inside, aclk, aresetn, state_reg == ST_SFT_CMP, node_reg < bound_reg)
    `HSE_ASSERT_NXT(a_last_leaves, aclk, aresetn, in_valid && in_ready && in_last,
                    state_reg != ST_LOAD)
    `HSE_ASSERT_IMP(a_ovf_full, aclk, aresetn, $rose(ovf_reg), count_reg == CW'(CAPACITY))

endmodule

@@ sv/heap_sort_engine_unit.sv @@
// channel | dir | tdata                   | tlast     | tuser
// s_      | in  | [31:0] value (signed)   | last      | -
// m_      | out | [31:0] sorted_value     | final_res | [0] overflow
//
// Loading accepts one beat per cycle; the store is a single memory with one
// read and one write port and a registered read.
// Sorting n values: heap build plus n-1 root extractions; each sift level
// reads the left child, reads the right child, then compares and writes.
// Results are then read out in order, each waiting for a free output slot.
// aresetn is synchronous, active low; it clears the count and the flag,
// not the store. An output register holds a stalled result beat.
module heap_sort_engine_unit import hse_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);

    localparam int unsigned AW = $clog2(CAPACITY);

    emit_t             emit;
    logic              slot_free;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_ovf_reg, m_ovf_next;

    hse_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .slot_free (slot_free),
        .emit      (emit),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    hse_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = mem_rdata;
            m_last_next  = emit.last;
            m_ovf_next   = emit.ovf;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench import hse_pkg::*;;

    localparam int unsigned DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] sorted_value;
        logic              final_res;
        logic              overflow;
    } sorted_beat_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;   // [31:0] value
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // [31:0] sorted_value
    logic              m_tlast;
    logic [0:0]        m_tuser;         // [0] overflow

    in_beat_t          pending_beats[$];
    sorted_beat_t      sorted_expect[$];
    in_beat_t          next_beat;
    sorted_beat_t      got_beat;
    sorted_beat_t      want_beat;

    // predictor state
    logic [DATA_W-1:0] held_values[DEPTH];
    int                held_count   = 0;
    logic              dropped_flag = 1'b0;

    int                send_idle_pct = 17;
    int                recv_idle_pct = 56;
    int                error_count   = 0;

    heap_sort_engine_unit #(
        .CAPACITY (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // sift entry node down within held_values[0..bound]
    task automatic sift_held(input int start, input int bound);
        int                node;
        int                child;
        logic              done;
        logic [DATA_W-1:0] tmp;
        node = start;
        done = 1'b0;
        while (!done && (2 * node + 1 <= bound)) begin
            child = 2 * node + 1;
            if (child < bound && $signed(held_values[child]) < $signed(held_values[child + 1]))
                child++;
            if ($signed(held_values[node]) < $signed(held_values[child])) begin
                tmp                 = held_values[node];
                held_values[node]   = held_values[child];
                held_values[child]  = tmp;
                node                = child;
            end else begin
                done = 1'b1;
            end
        end
    endtask

    task automatic accept_value(input logic [DATA_W-1:0] value, input logic last);
        int                n;
        int                i;
        logic [DATA_W-1:0] tmp;
        sorted_beat_t      beat;
        if (held_count < DEPTH) begin
            held_values[held_count] = value;
            held_count++;
        end else begin
            dropped_flag = 1'b1;
        end
        if (last) begin
            n = held_count;
            for (i = (n - 1) / 2; i >= 0; i--)
                sift_held(i, n - 1);
            for (i = n - 1; i > 0; i--) begin
                tmp            = held_values[0];
                held_values[0] = held_values[i];
                held_values[i] = tmp;
                sift_held(0, i - 1);
            end
            for (i = 0; i < n; i++) begin
                beat.sorted_value = held_values[i];
                beat.final_res    = (i == n - 1);
                beat.overflow     = dropped_flag;
                sorted_expect.push_back(beat);
            end
            held_count   = 0;
            dropped_flag = 1'b0;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                accept_value(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.value;
                    s_tlast  <= next_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_beat.sorted_value = m_tdata;
                got_beat.final_res    = m_tlast;
                got_beat.overflow     = m_tuser[0];
                if (sorted_expect.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected beat, expected none, actual value %h last %b ovf %b",
                             $time, got_beat.sorted_value, got_beat.final_res,
                             got_beat.overflow);
                end else begin
                    want_beat = sorted_expect.pop_front();
                    if (got_beat.sorted_value !== want_beat.sorted_value) begin
                        error_count++;
                        $display("%0t: sorted_value expected %h actual %h", $time,
                                 want_beat.sorted_value, got_beat.sorted_value);
                    end
                    if (got_beat.final_res !== want_beat.final_res) begin
                        error_count++;
                        $display("%0t: final_res expected %b actual %b", $time,
                                 want_beat.final_res, got_beat.final_res);
                    end
                    if (got_beat.overflow !== want_beat.overflow) begin
                        error_count++;
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want_beat.overflow, got_beat.overflow);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // extremes and small values mixed in so that duplicates are common
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return 32'($urandom_range(7)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_set(input logic [DATA_W-1:0] vals[$]);
        in_beat_t beat;
        for (int i = 0; i < vals.size(); i++) begin
            beat.value = vals[i];
            beat.last  = (i == vals.size() - 1);
            pending_beats.push_back(beat);
        end
    endtask

    task automatic push_random_set(input int size);
        logic [DATA_W-1:0] vals[$];
        for (int i = 0; i < size; i++)
            vals.push_back(pick_value());
        push_set(vals);
    endtask

    // one large set first, then small sets up to about target beats
    task automatic push_phase(input int big_size, input int target);
        int made;
        push_random_set(big_size);
        made = big_size;
        while (made < target) begin
            int size;
            size = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
            push_random_set(size);
            made += size;
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || sorted_expect.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed sets: single beat, extremes, duplicates, sorted and reversed input
        push_set('{32'h8000_0000});
        push_set('{32'h7fff_ffff, 32'h8000_0000});
        push_set('{32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
        push_set('{32'd1, 32'd2, 32'd3, 32'd4, 32'd5});
        push_set('{32'd5, 32'd4, 32'd3, 32'd2, 32'd1});

        // store exactly full, no drop
        push_phase(DEPTH, DEPTH + 4);
        wait_drained();

        send_idle_pct <= 56;
        recv_idle_pct <= 17;
        // last beat arrives with the store full and is dropped
        push_phase(DEPTH + 1, DEPTH + 4);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        push_phase(DEPTH + $urandom_range(2, 5), DEPTH + 6);
        wait_drained();

        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("[heap_sort_engine_unit] OK");
        end else begin
            $display("[heap_sort_engine_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout at %0t", $time);
        $display("[heap_sort_engine_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/hse_pkg.sv
sv/hse_ram.sv
sv/hse_ctrl.sv
sv/heap_sort_engine_unit.sv
bench/testbench.sv
